>>> rtl/cfbl_pkg.sv
// ----------------------------------------------------------------------------
// cfbl_pkg: shared types and constants of the chained free block list
// Beat formats, field codes, controller states and the command and status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cfbl_pkg;

	// Number of entries held in the on-chip stack (legal range 2 to 63).
	localparam int LIST_DEPTH = 32;

	localparam int IDX_W  = $clog2(LIST_DEPTH);
	localparam int MODE_W = 2;
	localparam int BLK_W  = 16;
	localparam int CNT_W  = 16;
	localparam int LIDX_W = 6;
	localparam int SIDX_W = 6;
	localparam int KIND_W = 2;

	// Request modes.
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

	// Response kinds.
	localparam logic [KIND_W-1:0] KIND_GRANT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_FREED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SPILL = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd3;

	// Error codes.
	localparam logic ERR_BAD_COUNT  = 1'b0;
	localparam logic ERR_ZERO_ENTRY = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [BLK_W-1:0]  block_number;
		logic [LIDX_W-1:0] load_index;
		logic [BLK_W-1:0]  load_value;
	} req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BLK_W-1:0]  granted_block;
		logic              refill_needed;
		logic [SIDX_W-1:0] spill_index;
		logic [BLK_W-1:0]  spill_value;
		logic              error_code;
		logic              last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_SPILL_CNT,
		ST_SPILL_ENT
	} state_t;

	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_RD_TOP,
		MEM_RD_FIRST,
		MEM_RD_NEXT,
		MEM_WR_PUSH,
		MEM_WR_LOAD,
		MEM_WR_RESTART
	} mem_op_t;

	typedef enum logic [2:0] {
		CNT_NONE,
		CNT_DEC,
		CNT_INC,
		CNT_LOAD,
		CNT_ONE
	} cnt_op_t;

	typedef enum logic [2:0] {
		OUT_NONE,
		OUT_ERR_COUNT,
		OUT_ERR_ZERO,
		OUT_GRANT,
		OUT_FREED,
		OUT_SPILL_CNT,
		OUT_SPILL_ENT
	} out_op_t;

	typedef enum logic [1:0] {
		K_HOLD,
		K_CLEAR,
		K_INC
	} k_op_t;

	typedef struct packed {
		mem_op_t mem_op;
		cnt_op_t cnt_op;
		out_op_t out_op;
		k_op_t   k_op;
		logic    cap_blk;
	} cmd_t;

	typedef struct packed {
		logic count_bad;
		logic count_full;
		logic ld_cnt;
		logic ld_ent;
		logic rd_zero;
		logic spill_last;
		logic out_free;
	} status_t;

endpackage

>>> rtl/cfbl_ctrl.sv
// ----------------------------------------------------------------------------
// cfbl_ctrl: controller of the chained free block list
// Sequences allocate, free, spill and load operations and issues datapath
// commands from the datapath status.
// ----------------------------------------------------------------------------
module cfbl_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_mode,
	output logic              req_ready,
	input  cfbl_pkg::status_t sts,
	output cfbl_pkg::cmd_t    cmd
);
	import cfbl_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign accept = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && req_mode == MODE_ALLOC && !sts.count_bad) begin
					state_d = ST_POP;
				end else if (accept && req_mode == MODE_FREE && sts.count_full) begin
					state_d = ST_SPILL_CNT;
				end
			end
			ST_POP: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SPILL_CNT: begin
				if (sts.out_free) begin
					state_d = ST_SPILL_ENT;
				end
			end
			ST_SPILL_ENT: begin
				if (sts.out_free && sts.spill_last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.mem_op  = MEM_NONE;
		cmd.cnt_op  = CNT_NONE;
		cmd.out_op  = OUT_NONE;
		cmd.k_op    = K_HOLD;
		cmd.cap_blk = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = sts.out_free;
				if (accept) begin
					case (req_mode)
						MODE_ALLOC: begin
							if (sts.count_bad) begin
								cmd.out_op = OUT_ERR_COUNT;
							end else begin
								cmd.mem_op = MEM_RD_TOP;
							end
						end
						MODE_FREE: begin
							if (sts.count_full) begin
								cmd.cap_blk = 1'b1;
							end else begin
								cmd.mem_op = MEM_WR_PUSH;
								cmd.cnt_op = CNT_INC;
								cmd.out_op = OUT_FREED;
							end
						end
						MODE_LOAD: begin
							if (sts.ld_cnt) begin
								cmd.cnt_op = CNT_LOAD;
							end else if (sts.ld_ent) begin
								cmd.mem_op = MEM_WR_LOAD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_POP: begin
				if (sts.out_free) begin
					if (sts.rd_zero) begin
						cmd.out_op = OUT_ERR_ZERO;
					end else begin
						cmd.out_op = OUT_GRANT;
						cmd.cnt_op = CNT_DEC;
					end
				end
			end
			ST_SPILL_CNT: begin
				if (sts.out_free) begin
					cmd.out_op = OUT_SPILL_CNT;
					cmd.mem_op = MEM_RD_FIRST;
					cmd.k_op   = K_CLEAR;
				end
			end
			ST_SPILL_ENT: begin
				if (sts.out_free) begin
					cmd.out_op = OUT_SPILL_ENT;
					if (sts.spill_last) begin
						cmd.mem_op = MEM_WR_RESTART;
						cmd.cnt_op = CNT_ONE;
					end else begin
						cmd.mem_op = MEM_RD_NEXT;
						cmd.k_op   = K_INC;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/cfbl_dp.sv
// ----------------------------------------------------------------------------
// cfbl_dp: datapath of the chained free block list
// Holds the free count, the stack memory, the spill counter and the response
// register, and reports status to the controller.
// ----------------------------------------------------------------------------
module cfbl_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  cfbl_pkg::req_t   req,
	input  cfbl_pkg::cmd_t   cmd,
	output cfbl_pkg::status_t sts,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output cfbl_pkg::rsp_t   rsp
);
	import cfbl_pkg::*;

	logic [BLK_W-1:0] stack_mem [LIST_DEPTH];
	logic [BLK_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [BLK_W-1:0] blk_q;
	logic [IDX_W-1:0] k_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;

	logic             mem_we;
	logic             mem_re;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_ra;
	logic [BLK_W-1:0] mem_wd;

	assign sts.count_bad  = (count_q == '0) || (count_q > CNT_W'(LIST_DEPTH));
	assign sts.count_full = count_q >= CNT_W'(LIST_DEPTH);
	assign sts.ld_cnt     = req.load_index == '0;
	assign sts.ld_ent     = (req.load_index != '0) &&
	                        (req.load_index <= LIDX_W'(LIST_DEPTH));
	assign sts.rd_zero    = rd_q == '0;
	assign sts.spill_last = k_q == IDX_W'(LIST_DEPTH - 1);
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		mem_wa = '0;
		mem_ra = '0;
		mem_wd = req.block_number;
		case (cmd.mem_op)
			MEM_RD_TOP: begin
				mem_re = 1'b1;
				mem_ra = IDX_W'(count_q - CNT_W'(1));
			end
			MEM_RD_FIRST: begin
				mem_re = 1'b1;
			end
			MEM_RD_NEXT: begin
				mem_re = 1'b1;
				mem_ra = k_q + IDX_W'(1);
			end
			MEM_WR_PUSH: begin
				mem_we = 1'b1;
				mem_wa = IDX_W'(count_q);
			end
			MEM_WR_LOAD: begin
				mem_we = 1'b1;
				mem_wa = IDX_W'(req.load_index - LIDX_W'(1));
				mem_wd = req.load_value;
			end
			MEM_WR_RESTART: begin
				mem_we = 1'b1;
				mem_wd = blk_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= stack_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			k_q     <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_DEC:  count_q <= count_q - CNT_W'(1);
				CNT_INC:  count_q <= count_q + CNT_W'(1);
				CNT_LOAD: count_q <= req.load_value;
				CNT_ONE:  count_q <= CNT_W'(1);
				default:  count_q <= count_q;
			endcase
			case (cmd.k_op)
				K_CLEAR: k_q <= '0;
				K_INC:   k_q <= k_q + IDX_W'(1);
				default: k_q <= k_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_blk) begin
			blk_q <= req.block_number;
		end
	end

	// Fields that mean nothing for a kind stay zero.
	always_comb begin
		rsp_d = '0;
		case (cmd.out_op)
			OUT_ERR_COUNT: begin
				rsp_d.kind       = KIND_ERROR;
				rsp_d.error_code = ERR_BAD_COUNT;
				rsp_d.last       = 1'b1;
			end
			OUT_ERR_ZERO: begin
				rsp_d.kind       = KIND_ERROR;
				rsp_d.error_code = ERR_ZERO_ENTRY;
				rsp_d.last       = 1'b1;
			end
			OUT_GRANT: begin
				rsp_d.kind          = KIND_GRANT;
				rsp_d.granted_block = rd_q;
				rsp_d.refill_needed = count_q == CNT_W'(1);
				rsp_d.last          = 1'b1;
			end
			OUT_FREED: begin
				rsp_d.kind          = KIND_FREED;
				rsp_d.granted_block = req.block_number;
				rsp_d.last          = 1'b1;
			end
			OUT_SPILL_CNT: begin
				rsp_d.kind          = KIND_SPILL;
				rsp_d.granted_block = blk_q;
				rsp_d.spill_value   = count_q;
			end
			OUT_SPILL_ENT: begin
				rsp_d.kind          = KIND_SPILL;
				rsp_d.granted_block = blk_q;
				rsp_d.spill_index   = SIDX_W'(k_q) + SIDX_W'(1);
				rsp_d.spill_value   = rd_q;
				rsp_d.last          = sts.spill_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_op != OUT_NONE) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_op != OUT_NONE) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/chained_free_block_list.sv
// ----------------------------------------------------------------------------
// chained_free_block_list: free block manager with a chained refill list
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// The block keeps a stack of up to LIST_DEPTH free block numbers and a count.
// An allocate beat reads the top entry from a stack memory with a single
// read port and a registered read, and examines it in the cycle after. An
// allocate that finds the count out of range answers at once from the idle
// state, as a free beat that finds room does; a load beat is also handled
// there. A free that finds the stack full produces LIST_DEPTH+1 spill beats,
// count first, one per cycle while the response side keeps ready high; the
// stack memory's one read port sets that pace. Responses leave through a
// one-deep output register, and a new request is taken as soon as that
// register is empty or being emptied in the same cycle, so req_ready follows
// rsp_ready combinationally while idle. Load beats fill the count and the
// entries after a grant that asks for a refill; they produce no response.
// Stack entries have no reset value and must be written before they are
// read. There is no clearing pass after reset.
module chained_free_block_list (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  cfbl_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output cfbl_pkg::rsp_t  rsp
);
	import cfbl_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// The controller only needs the mode; operands go straight to the datapath.
	cfbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_mode  (req.mode),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cfbl_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

>>> rtl/cfbl_checker.sv
// ----------------------------------------------------------------------------
// cfbl_checker: port-level checks of the chained free block list
// Watches the request and response channels of the top level and is bound
// to it.
// ----------------------------------------------------------------------------
module cfbl_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input cfbl_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input cfbl_pkg::rsp_t rsp
);
	import cfbl_pkg::*;

	// A request beat that waits keeps its valid and its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
	else $error("request beat changed while waiting");

	// A stalled response beat holds its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
	else $error("response beat changed while stalled");

	// Grants, frees and errors are single-beat responses.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.kind == KIND_GRANT || rsp.kind == KIND_FREED ||
		              rsp.kind == KIND_ERROR) |-> rsp.last)
	else $error("single-beat response without last");

	// The count word opens a spill and never ends it.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_SPILL && rsp.spill_index == '0 |-> !rsp.last)
	else $error("spill ended on its count word");

	// A refill request only comes with a grant.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.refill_needed |-> rsp.kind == KIND_GRANT)
	else $error("refill request on a non-grant response");

endmodule

bind chained_free_block_list cfbl_checker u_cfbl_checker (.*);

>>> tb/chained_free_block_list_tb.sv
// ----------------------------------------------------------------------------
// chained_free_block_list_tb: self-checking bench of the free block list
// Drives allocate, free and refill beats through the request channel,
// predicts every response beat from a behavioral copy of the stack, and
// compares each response field by field under random stalls on both sides.
// ----------------------------------------------------------------------------
module chained_free_block_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cfbl_pkg::*;

	// Mode 3 has no meaning in the block and must be swallowed silently.
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic [CNT_W-1:0] FULL_COUNT      = CNT_W'(LIST_DEPTH);
	localparam logic [CNT_W-1:0] OVERSIZED_COUNT = 16'd100;

	localparam int RESET_CYCLES  = 5;
	localparam int ITEM_TARGET   = 280;
	localparam int HANG_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 60;

	// The stack shadow exists twice: one copy runs ahead while the stimulus
	// is planned, so that no beat is ever planned that would read a stack
	// entry never written since reset; the other follows the beats the block
	// actually accepts and produces the responses it owes.
	localparam int unsigned PLAN_COPY = 0;
	localparam int unsigned LIVE_COPY = 1;

	localparam int unsigned SENDER   = 0;
	localparam int unsigned RECEIVER = 1;

	typedef struct packed {
		logic drain;
		req_t beat;
	} queued_req_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b1;
	rsp_t rsp;

	bit [CNT_W-1:0] list_count [2];
	bit [BLK_W-1:0] list_entry [2][LIST_DEPTH];
	bit             entry_written [2][LIST_DEPTH];

	queued_req_t request_backlog [$];
	rsp_t        owed_beats [$];

	bit          drain_next;
	int unsigned planned_items;
	int unsigned calm_left [2];
	int unsigned send_wait;
	int unsigned recv_wait;
	int unsigned rsp_seen;
	int unsigned mismatch_count;
	int unsigned idle_cycles;

	chained_free_block_list u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Applies one request beat to one copy of the stack. Only the live copy
	// queues the response beats that the block owes for it.
	function automatic void advance_free_list(int unsigned side, req_t r);
		rsp_t beat;
		int   top;
		int   k;
		bit   live;
		live = (side == LIVE_COPY);
		top = int'(list_count[side]) - 1;
		beat = '0;
		beat.last = 1'b1;
		case (r.mode)
		MODE_ALLOC: begin
			if (top < 0 || top >= LIST_DEPTH) begin
				beat.kind = KIND_ERROR;
				beat.error_code = ERR_BAD_COUNT;
			end else if (list_entry[side][top] == '0) begin
				// A zero entry marks the end of the chain; nothing is popped.
				beat.kind = KIND_ERROR;
				beat.error_code = ERR_ZERO_ENTRY;
			end else begin
				beat.kind = KIND_GRANT;
				beat.granted_block = list_entry[side][top];
				beat.refill_needed = (top == 0);
				list_count[side] = CNT_W'(top);
			end
			if (live) owed_beats.push_back(beat);
		end
		MODE_FREE: begin
			beat.granted_block = r.block_number;
			if (top >= LIST_DEPTH - 1) begin
				// Full (or oversized) list: the count as held and every entry
				// go out to the freed block, which then starts a fresh list.
				beat.kind = KIND_SPILL;
				beat.spill_value = list_count[side];
				beat.last = 1'b0;
				if (live) owed_beats.push_back(beat);
				for (k = 0; k < LIST_DEPTH; k++) begin
					beat.spill_index = SIDX_W'(k + 1);
					beat.spill_value = list_entry[side][k];
					beat.last = (k == LIST_DEPTH - 1);
					if (live) owed_beats.push_back(beat);
				end
				list_entry[side][0] = r.block_number;
				entry_written[side][0] = 1'b1;
				list_count[side] = CNT_W'(1);
			end else begin
				beat.kind = KIND_FREED;
				list_entry[side][top + 1] = r.block_number;
				entry_written[side][top + 1] = 1'b1;
				list_count[side] = CNT_W'(top + 2);
				if (live) owed_beats.push_back(beat);
			end
		end
		MODE_LOAD: begin
			if (r.load_index == '0) begin
				list_count[side] = r.load_value;
			end else if (r.load_index <= LIST_DEPTH) begin
				list_entry[side][int'(r.load_index) - 1] = r.load_value;
				entry_written[side][int'(r.load_index) - 1] = 1'b1;
			end
		end
		default: ;
		endcase
	endfunction

	// True when the beat would make the block read an unwritten stack entry.
	function automatic bit reads_unwritten(req_t r);
		int top;
		int k;
		bit hole;
		top = int'(list_count[PLAN_COPY]) - 1;
		hole = 1'b0;
		if (r.mode == MODE_ALLOC && top >= 0 && top < LIST_DEPTH)
			hole = !entry_written[PLAN_COPY][top];
		if (r.mode == MODE_FREE && top >= LIST_DEPTH - 1)
			for (k = 0; k < LIST_DEPTH; k++)
				if (!entry_written[PLAN_COPY][k]) hole = 1'b1;
		return hole;
	endfunction

	function automatic void plan(req_t r);
		if (reads_unwritten(r)) return;
		request_backlog.push_back({drain_next, r});
		drain_next = 1'b0;
		advance_free_list(PLAN_COPY, r);
		planned_items++;
	endfunction

	function automatic req_t noise_req();
		req_t r;
		r.mode = MODE_W'($urandom_range(0, 3));
		r.block_number = BLK_W'($urandom);
		r.load_index = LIDX_W'($urandom);
		r.load_value = BLK_W'($urandom);
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] pick_block();
		case ($urandom_range(0, 15))
		0: return '0;
		1: return '1;
		default: return BLK_W'($urandom_range(1, 65535));
		endcase
	endfunction

	function automatic logic [CNT_W-1:0] odd_count();
		case ($urandom_range(0, 5))
		0: return '0;
		1: return FULL_COUNT;
		2: return FULL_COUNT + 1'b1;
		3: return OVERSIZED_COUNT;
		4: return '1;
		default: return CNT_W'($urandom);
		endcase
	endfunction

	function automatic void plan_alloc();
		req_t r;
		r = noise_req();
		r.mode = MODE_ALLOC;
		plan(r);
	endfunction

	function automatic void plan_free(logic [BLK_W-1:0] blk);
		req_t r;
		r = noise_req();
		r.mode = MODE_FREE;
		r.block_number = blk;
		plan(r);
	endfunction

	function automatic void plan_load(int unsigned idx, logic [BLK_W-1:0] val);
		req_t r;
		r = noise_req();
		r.mode = MODE_LOAD;
		r.load_index = LIDX_W'(idx);
		r.load_value = val;
		plan(r);
	endfunction

	// Sends a refill as the host would after reading a chained block: the
	// count word and the entries. A messy refill mixes in zero entries and
	// words aimed past the end of the stack.
	function automatic void plan_refill(logic [CNT_W-1:0] cnt, int unsigned entries, bit messy);
		int unsigned k;
		bit          cnt_last;
		cnt_last = 1'($urandom_range(0, 1));
		if (!cnt_last) plan_load(0, cnt);
		for (k = 1; k <= entries; k++) begin
			plan_load(k, (messy && $urandom_range(0, 5) == 0) ? '0 : pick_block());
			if (messy && $urandom_range(0, 7) == 0)
				plan_load($urandom_range(LIST_DEPTH + 1, 63), BLK_W'($urandom));
		end
		if (cnt_last) plan_load(0, cnt);
	endfunction

	// At least half the beats go without a pause; now and then a stretch of 8
	// to 40 beats runs at full rate on one side.
	function automatic int unsigned draw_pause(int unsigned side);
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0) begin
			calm_left[side] = $urandom_range(8, 40);
			return 0;
		end
		return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 12);
	endfunction

	task automatic report(string what);
		mismatch_count++;
		$display("%0t ns: %s", $time, what);
	endtask

	task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("response beat %0d: %s is %0h, should be %0h",
				rsp_seen, name, got, want));
	endtask

	// Request driver. After an accepted beat the next one waits a drawn number
	// of cycles; a beat marked for draining is held back until every owed
	// response has arrived. With no pause the next beat follows at once, so
	// req_valid stays high across back-to-back beats.
	always @(posedge clk) begin : drive_requests
		logic show;
		if (arst_n) begin
			show = req_valid;
			if (req_valid && req_ready) begin
				advance_free_list(LIVE_COPY, req);
				show = 1'b0;
				send_wait = draw_pause(SENDER);
			end
			if (!show) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (request_backlog.size() > 0 &&
						(!request_backlog[0].drain || owed_beats.size() == 0)) begin
					req <= request_backlog[0].beat;
					request_backlog.pop_front();
					show = 1'b1;
				end
			end
			req_valid <= show;
		end
	end

	// Response monitor. Every accepted beat is matched with the oldest owed
	// beat; afterwards rsp_ready drops for a drawn number of cycles.
	always @(posedge clk) begin : watch_responses
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (owed_beats.size() == 0) begin
					report($sformatf("response beat %0d arrived with nothing owed", rsp_seen));
				end else begin
					want = owed_beats.pop_front();
					compare_field("kind", 32'(rsp.kind), 32'(want.kind));
					compare_field("granted_block", 32'(rsp.granted_block),
						32'(want.granted_block));
					compare_field("refill_needed", 32'(rsp.refill_needed),
						32'(want.refill_needed));
					compare_field("spill_index", 32'(rsp.spill_index),
						32'(want.spill_index));
					compare_field("spill_value", 32'(rsp.spill_value),
						32'(want.spill_value));
					compare_field("error_code", 32'(rsp.error_code),
						32'(want.error_code));
					compare_field("last", 32'(rsp.last), 32'(want.last));
				end
				recv_wait = draw_pause(RECEIVER);
				rsp_ready <= (recv_wait == 0);
			end else if (recv_wait > 0) begin
				recv_wait--;
				rsp_ready <= (recv_wait == 0);
			end
		end
	end

	// Hang detector: no beat on either channel for too long ends the run.
	always @(posedge clk) begin : watchdog
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == HANG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		req_t        odd;
		int unsigned goal;
		int unsigned n;
		int unsigned i;
		int unsigned fill;

		// Directed opening: allocate from an empty list, the unused mode with
		// every field bit set, a refill word past the end of the stack, a zero
		// entry on top, grants down to a refill request, a zero block freed
		// and then met by an allocate, out-of-range counts.
		plan_alloc();
		odd = noise_req();
		odd.mode = MODE_UNUSED;
		odd.block_number = '1;
		odd.load_index = '1;
		odd.load_value = '1;
		plan(odd);
		plan_load(63, '1);
		plan_load(0, 16'd2);
		plan_load(1, '1);
		plan_load(2, '0);
		plan_alloc();
		plan_load(2, 16'd1);
		plan_alloc();
		plan_alloc();
		plan_alloc();
		plan_free('1);
		plan_free('0);
		plan_alloc();
		plan_load(0, OVERSIZED_COUNT);
		plan_alloc();
		plan_load(0, FULL_COUNT + 1'b1);
		plan_alloc();
		plan_load(0, 16'd1);
		plan_alloc();

		// A full refill holding an oversized count, then a free that spills
		// it. The beat after that waits until the spill has fully drained.
		plan_refill(OVERSIZED_COUNT, LIST_DEPTH, 1'b0);
		plan_free(pick_block());
		drain_next = 1'b1;
		plan_refill(FULL_COUNT, LIST_DEPTH, 1'b0);
		plan_alloc();
		plan_free(pick_block());
		plan_free(pick_block());

		goal = ITEM_TARGET;
		while (planned_items < goal) begin
			case ($urandom_range(0, 19))
			0, 1, 2, 3, 4, 5: begin
				// Allocation run; an emptied list is usually refilled from
				// the last granted block, as a well-behaved host does.
				n = $urandom_range(1, 6);
				for (i = 0; i < n; i++) begin
					plan_alloc();
					if (list_count[PLAN_COPY] == '0 && $urandom_range(0, 4) != 0) begin
						fill = ($urandom_range(0, 3) == 0) ? LIST_DEPTH : $urandom_range(1, 8);
						plan_refill(CNT_W'(fill), fill, 1'b0);
					end
				end
			end
			6, 7, 8, 9, 10: begin
				n = $urandom_range(1, 8);
				for (i = 0; i < n; i++) plan_free(pick_block());
			end
			11, 12: begin
				// Free until the list is full, then once more to spill it.
				while (list_count[PLAN_COPY] < FULL_COUNT) plan_free(pick_block());
				plan_free(pick_block());
			end
			13, 14: begin
				plan_refill(odd_count(), $urandom_range(1, LIST_DEPTH), 1'b1);
				n = $urandom_range(1, 3);
				for (i = 0; i < n; i++) plan_alloc();
			end
			15: begin
				plan_refill(odd_count(), LIST_DEPTH, 1'($urandom_range(0, 1)));
				plan_free(pick_block());
			end
			16, 17: begin
				n = $urandom_range(1, 4);
				for (i = 0; i < n; i++) plan(noise_req());
			end
			18: begin
				drain_next = 1'b1;
			end
			default: begin
				n = $urandom_range(4, 16);
				for (i = 0; i < n && list_count[PLAN_COPY] != '0; i++) plan_alloc();
			end
			endcase
		end

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		while (request_backlog.size() != 0 || req_valid || owed_beats.size() != 0)
			@(posedge clk);
		// Let any stray response beat show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
